// File: hw/rtl/tsp_cost_matrix_reduce_regret_macros.svh
// Assertion macros shared by the cost-matrix engine
`ifndef TSP_COST_MATRIX_REDUCE_REGRET_MACROS_SVH
`define TSP_COST_MATRIX_REDUCE_REGRET_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define TCMR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted
`define TCMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/tcmr_pkg.sv
// Shared types and constants of the cost-matrix engine
package tcmr_pkg;

    localparam int VALUE_W  = 22;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 22'h3F_FFFF;
    localparam int IDX_W    = 6;    // widest row or column index over the SIZE range
    localparam int SIZE_W   = 5;
    localparam int WIDE_W   = 33;   // holds any cost plus any saturated sum
    localparam int CMP_W    = 8;
    localparam int PADDR_W  = 2;
    localparam logic [PADDR_W-1:0] ADDR_MATRIX_SIZE = 2'd0;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_READ   = 3'd1,
        OP_DCELL  = 3'd2,
        OP_DROW   = 3'd3,
        OP_DCOL   = 3'd4,
        OP_REDUCE = 3'd5,
        OP_REGRET = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOZERO = 2'd2
    } t_status;

    // Work done on read data in the cycle after the read is issued
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_MIN,
        ACT_SUB,
        ACT_STAT,
        ACT_SCAN
    } t_act;

    typedef enum logic {
        WR_LOAD,
        WR_DIS
    } t_wr;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_RANGE,
        RES_READ,
        RES_SUM,
        RES_REGRET
    } t_res;

    typedef struct packed {
        logic             clr_op;
        logic             rd_en;
        logic             wr_en;
        t_wr              wr_sel;
        logic             addr_in;
        logic             by_row;
        logic [IDX_W-1:0] line;
        logic [IDX_W-1:0] k;
        t_act             act;
        logic             acc_clr;
        logic             sum_add;
        logic             cs_wr;
        logic             finish;
        t_res             res;
    } t_dp_cmd;

endpackage

// File: hw/rtl/tsp_cost_matrix_reduce_regret.sv
// Top level of the cost-matrix engine: register port, sequencer and datapath
//
//  channel   handshake                         transfer
//  command   i_start high while o_busy low     op, indices, cost, disabled flag
//  result    o_done strobe for one cycle       status, value, row, column, flag
//  config    psel & penable & pwrite & pready  matrix_size at byte address 0
//
//  Load, disable cell, range error and undefined op report without going busy; read
//  waits for the registered RAM data; disable row or column, reduce and max regret walk
//  the matrix line by line. The matrix RAM reads at most one entry per cycle. Reset is
//  synchronous and leaves the matrix contents undefined until loaded. Results cannot
//  be held off.
`include "tsp_cost_matrix_reduce_regret_macros.svh"

module tsp_cost_matrix_reduce_regret #(
    parameter int SIZE      = 16,
    parameter int COST_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [2:0]                    i_op,
    input  logic [3:0]                    i_row_index,
    input  logic [3:0]                    i_col_index,
    input  logic [15:0]                   i_cost_in,
    input  logic                          i_disabled_in,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [tcmr_pkg::VALUE_W-1:0]  o_value_out,
    output logic [3:0]                    o_row_out,
    output logic [3:0]                    o_col_out,
    output logic                          o_disabled_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcmr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SZW = tcmr_pkg::SIZE_W;
    localparam logic [SZW-1:0] SIZE_MAX = (SIZE > 31) ? SZW'(31) : SZW'(SIZE);

    logic [SZW-1:0]    r_size, n_size;
    logic [SZW-1:0]    wr_size;
    tcmr_pkg::t_dp_cmd cmd;

    // Clamp written size into 1..SIZE, capped at 31
    always_comb begin
        wr_size = pwdata[SZW-1:0];
        n_size  = r_size;
        if (psel && penable && pwrite && (paddr == tcmr_pkg::ADDR_MATRIX_SIZE)) begin
            if (wr_size == '0) begin
                n_size = SZW'(1);
            end else if (wr_size > SIZE_MAX) begin
                n_size = SIZE_MAX;
            end else begin
                n_size = wr_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_MAX;
        end else begin
            r_size <= n_size;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == tcmr_pkg::ADDR_MATRIX_SIZE) ? 32'(r_size) : 32'd0;

    tcmr_ctrl #(
        .SIZE (SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_op        (i_op),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_size      (r_size),
        .o_busy      (o_busy),
        .o_cmd       (cmd)
    );

    tcmr_dp #(
        .SIZE      (SIZE),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_cost_in      (i_cost_in),
        .i_disabled_in  (i_disabled_in),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_value_out    (o_value_out),
        .o_row_out      (o_row_out),
        .o_col_out      (o_col_out),
        .o_disabled_out (o_disabled_out)
    );

    // An accepted op either starts work or reports at once
    `TCMR_ASSERT_NEXT(a_accept_moves, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)
    // Size register never leaves 1..SIZE (capped at 31) after a write
    `TCMR_ASSERT_NEXT(a_size_clamped, i_clk, i_rst_n, psel && penable && pwrite, (r_size != '0) && (r_size <= SIZE_MAX))
    // A regret without zero reports nothing else
    `TCMR_ASSERT_IMPLY(a_nozero_clean, i_clk, i_rst_n, o_done && (o_status == tcmr_pkg::ST_NOZERO), (o_value_out == '0) && (o_row_out == '0) && (o_col_out == '0))

endmodule

// File: hw/rtl/tcmr_ram.sv
// Generic single-write, single-read RAM with registered read data
module tcmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/tcmr_ctrl.sv
// Sequencer: decodes each op and walks the matrix line by line
module tcmr_ctrl #(
    parameter int SIZE = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2:0]                   i_op,
    input  logic [3:0]                   i_row_index,
    input  logic [3:0]                   i_col_index,
    input  logic [tcmr_pkg::SIZE_W-1:0]  i_size,
    output logic                         o_busy,
    output tcmr_pkg::t_dp_cmd            o_cmd
);

    localparam int IW = $clog2(SIZE);
    localparam int KW = $clog2(SIZE + 1);
    localparam int CW = tcmr_pkg::CMP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_DIS_LINE,
        S_RED_MIN,
        S_RED_SUB,
        S_RG_CSTAT,
        S_RG_RSTAT,
        S_RG_SCAN,
        S_FINISH
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_line, n_line;
    logic [KW-1:0]   r_k, n_k;
    logic            r_by_row, n_by_row;
    tcmr_pkg::t_res  r_res, n_res;
    tcmr_pkg::t_dp_cmd cmd;

    logic k_end, k_last, line_last, row_bad, col_bad;

    assign k_end     = (CW'(r_k) == CW'(i_size));
    assign k_last    = ((CW'(r_k) + CW'(1)) == CW'(i_size));
    assign line_last = ((CW'(r_line) + CW'(1)) == CW'(i_size));
    assign row_bad   = (CW'(i_row_index) >= CW'(i_size));
    assign col_bad   = (CW'(i_col_index) >= CW'(i_size));

    // Next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_line   = r_line;
        n_k      = r_k;
        n_by_row = r_by_row;
        n_res    = r_res;
        cmd        = '0;
        cmd.line   = tcmr_pkg::IDX_W'(r_line);
        cmd.k      = tcmr_pkg::IDX_W'(r_k);
        cmd.by_row = r_by_row;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.clr_op = 1'b1;
                    cmd.line   = tcmr_pkg::IDX_W'(i_row_index);
                    cmd.k      = tcmr_pkg::IDX_W'(i_col_index);
                    n_k        = '0;
                    n_line     = '0;
                    unique case (tcmr_pkg::t_op'(i_op))
                        tcmr_pkg::OP_LOAD, tcmr_pkg::OP_DCELL: begin
                            cmd.finish = 1'b1;
                            if (row_bad || col_bad) begin
                                cmd.res = tcmr_pkg::RES_RANGE;
                            end else begin
                                cmd.res     = tcmr_pkg::RES_ZERO;
                                cmd.wr_en   = 1'b1;
                                cmd.addr_in = 1'b1;
                                cmd.wr_sel  = (tcmr_pkg::t_op'(i_op) == tcmr_pkg::OP_LOAD)
                                              ? tcmr_pkg::WR_LOAD : tcmr_pkg::WR_DIS;
                            end
                        end
                        tcmr_pkg::OP_READ: begin
                            if (row_bad || col_bad) begin
                                cmd.finish = 1'b1;
                                cmd.res    = tcmr_pkg::RES_RANGE;
                            end else begin
                                cmd.rd_en   = 1'b1;
                                cmd.addr_in = 1'b1;
                                n_line      = IW'(i_row_index);
                                n_k         = KW'(i_col_index);
                                n_state     = S_RD_WAIT;
                            end
                        end
                        tcmr_pkg::OP_DROW: begin
                            if (row_bad) begin
                                cmd.finish = 1'b1;
                                cmd.res    = tcmr_pkg::RES_RANGE;
                            end else begin
                                n_line   = IW'(i_row_index);
                                n_by_row = 1'b1;
                                n_state  = S_DIS_LINE;
                            end
                        end
                        tcmr_pkg::OP_DCOL: begin
                            if (col_bad) begin
                                cmd.finish = 1'b1;
                                cmd.res    = tcmr_pkg::RES_RANGE;
                            end else begin
                                n_line   = IW'(i_col_index);
                                n_by_row = 1'b0;
                                n_state  = S_DIS_LINE;
                            end
                        end
                        tcmr_pkg::OP_REDUCE: begin
                            n_by_row = 1'b1;
                            n_state  = S_RED_MIN;
                        end
                        tcmr_pkg::OP_REGRET: begin
                            n_by_row = 1'b0;
                            n_state  = S_RG_CSTAT;
                        end
                        default: begin
                            cmd.finish = 1'b1;
                            cmd.res    = tcmr_pkg::RES_ZERO;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                cmd.finish = 1'b1;
                cmd.res    = tcmr_pkg::RES_READ;
                n_state    = S_IDLE;
            end
            S_DIS_LINE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tcmr_pkg::WR_DIS;
                if (k_last) begin
                    n_res   = tcmr_pkg::RES_ZERO;
                    n_state = S_FINISH;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_RED_MIN: begin
                if (!k_end) begin
                    cmd.rd_en   = 1'b1;
                    cmd.act     = tcmr_pkg::ACT_MIN;
                    cmd.acc_clr = (r_k == '0);
                    n_k         = r_k + 1'b1;
                end else begin
                    cmd.sum_add = 1'b1;
                    n_k         = '0;
                    n_state     = S_RED_SUB;
                end
            end
            S_RED_SUB: begin
                if (!k_end) begin
                    cmd.rd_en = 1'b1;
                    cmd.act   = tcmr_pkg::ACT_SUB;
                    n_k       = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (line_last) begin
                        n_line = '0;
                        if (r_by_row) begin
                            n_by_row = 1'b0;
                            n_state  = S_RED_MIN;
                        end else begin
                            n_res   = tcmr_pkg::RES_SUM;
                            n_state = S_FINISH;
                        end
                    end else begin
                        n_line  = r_line + 1'b1;
                        n_state = S_RED_MIN;
                    end
                end
            end
            S_RG_CSTAT: begin
                if (!k_end) begin
                    cmd.rd_en   = 1'b1;
                    cmd.act     = tcmr_pkg::ACT_STAT;
                    cmd.acc_clr = (r_k == '0);
                    n_k         = r_k + 1'b1;
                end else begin
                    cmd.cs_wr = 1'b1;
                    n_k       = '0;
                    if (line_last) begin
                        n_line   = '0;
                        n_by_row = 1'b1;
                        n_state  = S_RG_RSTAT;
                    end else begin
                        n_line = r_line + 1'b1;
                    end
                end
            end
            S_RG_RSTAT: begin
                if (!k_end) begin
                    cmd.rd_en   = 1'b1;
                    cmd.act     = tcmr_pkg::ACT_STAT;
                    cmd.acc_clr = (r_k == '0);
                    n_k         = r_k + 1'b1;
                end else begin
                    n_k     = '0;
                    n_state = S_RG_SCAN;
                end
            end
            S_RG_SCAN: begin
                if (!k_end) begin
                    cmd.rd_en = 1'b1;
                    cmd.act   = tcmr_pkg::ACT_SCAN;
                    n_k       = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (line_last) begin
                        n_res   = tcmr_pkg::RES_REGRET;
                        n_state = S_FINISH;
                    end else begin
                        n_line  = r_line + 1'b1;
                        n_state = S_RG_RSTAT;
                    end
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                cmd.res    = r_res;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_line   <= '0;
            r_k      <= '0;
            r_by_row <= 1'b0;
            r_res    <= tcmr_pkg::RES_ZERO;
        end else begin
            r_state  <= n_state;
            r_line   <= n_line;
            r_k      <= n_k;
            r_by_row <= n_by_row;
            r_res    <= n_res;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

endmodule

// File: hw/rtl/tcmr_dp.sv
// Datapath: matrix store, column statistics store, line minima and result registers
module tcmr_dp #(
    parameter int SIZE      = 16,
    parameter int COST_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcmr_pkg::t_dp_cmd             i_cmd,
    input  logic [3:0]                    i_row_index,
    input  logic [3:0]                    i_col_index,
    input  logic [15:0]                   i_cost_in,
    input  logic                          i_disabled_in,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [tcmr_pkg::VALUE_W-1:0]  o_value_out,
    output logic [3:0]                    o_row_out,
    output logic [3:0]                    o_col_out,
    output logic                          o_disabled_out
);

    localparam int IW = $clog2(SIZE);
    localparam int AW = $clog2(SIZE * SIZE);
    localparam int CB = COST_BITS;
    localparam int DW = COST_BITS + 1;
    localparam int VW = tcmr_pkg::VALUE_W;
    localparam int XW = tcmr_pkg::WIDE_W;
    localparam int SW = 2 * VW + IW;

    // Read side, registered copies of the issuing command's tag and coordinates
    tcmr_pkg::t_act r_act;
    logic [AW-1:0]  r_daddr;
    logic [IW-1:0]  r_drow, r_dcol;
    logic           r_dby_row;

    // Accumulators
    logic [CB-1:0]  r_min, n_min;
    logic           r_any, n_any;
    logic [VW-1:0]  r_sum, n_sum;
    logic [VW-1:0]  r_m1, n_m1, r_m2, n_m2;
    logic [IW-1:0]  r_arg, n_arg;
    logic [VW-1:0]  r_best, n_best;
    logic [IW-1:0]  r_bi, n_bi, r_bj, n_bj;
    logic           r_found, n_found;

    logic [IW-1:0]  row_sel, col_sel;
    logic [AW-1:0]  addr, wr_addr;
    logic [DW-1:0]  wr_data, rd_data;
    logic           wr_en;
    logic           rd_dis;
    logic [CB-1:0]  rd_cost;
    logic [SW-1:0]  cs_wr_data, cs_rd_data;
    logic [VW-1:0]  cs_m1, cs_m2;
    logic [IW-1:0]  cs_arg;
    logic [IW-1:0]  d_pos;
    logic [VW-1:0]  row_part, col_part, regret;
    logic [VW:0]    regret_sum;
    logic [XW-1:0]  sum_wide;

    // Matrix coordinates of the issuing command
    always_comb begin
        if (i_cmd.addr_in) begin
            row_sel = IW'(i_row_index);
            col_sel = IW'(i_col_index);
        end else if (i_cmd.by_row) begin
            row_sel = IW'(i_cmd.line);
            col_sel = IW'(i_cmd.k);
        end else begin
            row_sel = IW'(i_cmd.k);
            col_sel = IW'(i_cmd.line);
        end
        addr = AW'(AW'(row_sel) * AW'(SIZE)) + AW'(col_sel);
    end

    assign rd_dis  = rd_data[DW-1];
    assign rd_cost = rd_data[CB-1:0];

    // Select the write: subtract write-back has the port during reduce
    always_comb begin
        wr_en   = i_cmd.wr_en;
        wr_addr = addr;
        if (i_cmd.wr_sel == tcmr_pkg::WR_LOAD) begin
            wr_data = {i_disabled_in, i_disabled_in ? CB'(0) : CB'(i_cost_in)};
        end else begin
            wr_data = {1'b1, CB'(0)};
        end
        if (r_act == tcmr_pkg::ACT_SUB) begin
            wr_en   = !rd_dis;
            wr_addr = r_daddr;
            wr_data = {1'b0, rd_cost - r_min};
        end
    end

    tcmr_ram #(
        .WIDTH (DW),
        .DEPTH (SIZE * SIZE)
    ) u_matrix_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    // Per-column least and second-least cost with the row of the least
    assign cs_wr_data = {n_m1, n_m2, n_arg};
    assign {cs_m1, cs_m2, cs_arg} = cs_rd_data;

    tcmr_ram #(
        .WIDTH (SW),
        .DEPTH (SIZE)
    ) u_colstat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.cs_wr),
        .i_wr_addr (IW'(i_cmd.line)),
        .i_wr_data (cs_wr_data),
        .i_rd_en   (i_cmd.rd_en && (i_cmd.act == tcmr_pkg::ACT_SCAN)),
        .i_rd_addr (IW'(i_cmd.k)),
        .o_rd_data (cs_rd_data)
    );

    // Regret of the zero being scanned: least elsewhere in row plus in column
    assign d_pos      = r_dby_row ? r_dcol : r_drow;
    assign row_part   = (r_arg == r_dcol) ? r_m2 : r_m1;
    assign col_part   = (cs_arg == r_drow) ? cs_m2 : cs_m1;
    assign regret_sum = (VW + 1)'(row_part) + (VW + 1)'(col_part);
    assign regret     = regret_sum[VW] ? tcmr_pkg::VALUE_MAX : regret_sum[VW-1:0];

    // Accumulator updates
    always_comb begin
        n_min   = r_min;
        n_any   = r_any;
        n_sum   = r_sum;
        n_m1    = r_m1;
        n_m2    = r_m2;
        n_arg   = r_arg;
        n_best  = r_best;
        n_bi    = r_bi;
        n_bj    = r_bj;
        n_found = r_found;
        if (i_cmd.acc_clr) begin
            n_min = '0;
            n_any = 1'b0;
            n_m1  = tcmr_pkg::VALUE_MAX;
            n_m2  = tcmr_pkg::VALUE_MAX;
            n_arg = '0;
        end else begin
            case (r_act)
                tcmr_pkg::ACT_MIN: begin
                    if (!rd_dis && (!r_any || (rd_cost < r_min))) begin
                        n_min = rd_cost;
                        n_any = 1'b1;
                    end
                end
                tcmr_pkg::ACT_STAT: begin
                    if (!rd_dis) begin
                        if (XW'(rd_cost) < XW'(r_m1)) begin
                            n_m2  = r_m1;
                            n_m1  = VW'(rd_cost);
                            n_arg = d_pos;
                        end else if (XW'(rd_cost) < XW'(r_m2)) begin
                            n_m2 = VW'(rd_cost);
                        end
                    end
                end
                tcmr_pkg::ACT_SCAN: begin
                    if (!rd_dis && (rd_cost == '0) && (!r_found || (regret >= r_best))) begin
                        n_best  = regret;
                        n_bi    = r_drow;
                        n_bj    = r_dcol;
                        n_found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        sum_wide = XW'(r_sum) + XW'(n_min);
        if (i_cmd.sum_add) begin
            n_sum = (sum_wide > XW'(tcmr_pkg::VALUE_MAX)) ? tcmr_pkg::VALUE_MAX
                                                          : VW'(sum_wide);
        end
        if (i_cmd.clr_op) begin
            n_sum   = '0;
            n_best  = '0;
            n_found = 1'b0;
        end
    end

    // Register the read tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= tcmr_pkg::ACT_NONE;
        end else begin
            r_act <= i_cmd.act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr   <= addr;
        r_drow    <= row_sel;
        r_dcol    <= col_sel;
        r_dby_row <= i_cmd.by_row;
        r_min     <= n_min;
        r_any     <= n_any;
        r_sum     <= n_sum;
        r_m1      <= n_m1;
        r_m2      <= n_m2;
        r_arg     <= n_arg;
        r_best    <= n_best;
        r_bi      <= n_bi;
        r_bj      <= n_bj;
        r_found   <= n_found;
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
        end
    end

    // Result fields for the finishing op
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status       <= tcmr_pkg::ST_OK;
            o_value_out    <= '0;
            o_row_out      <= '0;
            o_col_out      <= '0;
            o_disabled_out <= 1'b0;
            case (i_cmd.res)
                tcmr_pkg::RES_RANGE: begin
                    o_status <= tcmr_pkg::ST_RANGE;
                end
                tcmr_pkg::RES_READ: begin
                    o_value_out    <= VW'(rd_cost);
                    o_row_out      <= 4'(i_cmd.line);
                    o_col_out      <= 4'(i_cmd.k);
                    o_disabled_out <= rd_dis;
                end
                tcmr_pkg::RES_SUM: begin
                    o_value_out <= r_sum;
                end
                tcmr_pkg::RES_REGRET: begin
                    if (r_found) begin
                        o_value_out <= r_best;
                        o_row_out   <= 4'(r_bi);
                        o_col_out   <= 4'(r_bj);
                    end else begin
                        o_status <= tcmr_pkg::ST_NOZERO;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
